@@ hw/rtl/tszc_pkg.sv @@
// Shared types, constants and the arctangent step table of the slope zone classifier.
// Used by every module of the block. It has no dependencies.
`default_nettype none

package tszc_pkg;

   localparam int MAX_COLS_DEF    = 1024;
   localparam int MAX_ROWS_DEF    = 4096;
   localparam int HEIGHT_BITS_DEF = 16;

   localparam int ROWS_W     = 13;
   localparam int COLS_W     = 11;
   localparam int ROW_CNT_W  = 14;
   localparam int THR_W      = 16;
   localparam int ANG_W      = 11;
   localparam int SUM_W      = 12;
   localparam int OUT_ROW_W  = 12;
   localparam int OUT_COL_W  = 10;
   localparam int GO_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int LANES      = 8;
   localparam int DIRS       = 4;
   localparam int STEPS      = 16;
   localparam int FRAC_BITS  = 14;
   localparam int Z_W        = 19;
   localparam int X_START    = 6;
   localparam int ANGLE_MAX  = 1440;
   localparam int ROUND_OFS  = 32;
   localparam int ANG_SHIFT  = 6;
   localparam int QUEUE_DEPTH = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT    = 3'd0,
      CSR_COL_COUNT    = 3'd1,
      CSR_MAX_AIR      = 3'd2,
      CSR_MIN_LAND     = 3'd3,
      CSR_MAX_LAND     = 3'd4,
      CSR_DANGER_ANGLE = 3'd5,
      CSR_MAX_ANGLE    = 3'd6
   } csr_index_type;

   typedef enum logic [GO_W-1:0] {
      GO_NORMAL    = 2'd0,
      GO_DANGER    = 2'd1,
      GO_FORBIDDEN = 2'd2
   } go_class_type;

   typedef struct packed {
      logic signed [THR_W-1:0] max_air;
      logic signed [THR_W-1:0] min_land;
      logic signed [THR_W-1:0] max_land;
      logic [ANG_W-1:0]        danger_angle;
      logic [ANG_W-1:0]        max_angle;
   } thr_cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } emit_info_type;

   typedef struct packed {
      logic                 valid;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
      logic                 fly;
      logic                 band;
      logic [LANES-1:0]     zero;
   } back_meta_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic [GO_W-1:0]      go;
      logic                 fly;
      logic                 last;
   } rsp_entry_type;

   // atan(2^-i) in 1/1024 degree
   function automatic logic signed [Z_W-1:0] atan_step(input logic [3:0] i);
      logic signed [Z_W-1:0] t;
      case (i)
         4'd0:    t = 19'sd46080;
         4'd1:    t = 19'sd27203;
         4'd2:    t = 19'sd14373;
         4'd3:    t = 19'sd7296;
         4'd4:    t = 19'sd3662;
         4'd5:    t = 19'sd1833;
         4'd6:    t = 19'sd917;
         4'd7:    t = 19'sd458;
         4'd8:    t = 19'sd229;
         4'd9:    t = 19'sd115;
         4'd10:   t = 19'sd57;
         4'd11:   t = 19'sd29;
         4'd12:   t = 19'sd14;
         4'd13:   t = 19'sd7;
         4'd14:   t = 19'sd4;
         default: t = 19'sd2;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tszc_front.sv @@
// Front part: raster counters, line buffer memory, 3x3 window and output cell counters.
// Depends on tszc_pkg; feeds one window snapshot per emitted cell to tszc_back.
`default_nettype none

module tszc_front import tszc_pkg::*; #(
   parameter int MAX_COLS    = MAX_COLS_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [ROWS_W-1:0]             rc,
   input  wire logic [COLS_W-1:0]             cc,
   input  wire logic                          accept,
   input  wire logic                          action,
   input  wire logic signed [HEIGHT_BITS-1:0] height,
   output logic                               drop,
   output emit_info_type                      info,
   output logic signed [HEIGHT_BITS-1:0]      win [3][3]
);

   localparam int HB = HEIGHT_BITS;
   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [ROW_CNT_W-1:0] in_row_ff, in_row_in;
   logic [COLS_W-1:0]    in_col_ff, in_col_in;
   logic [ROW_CNT_W-1:0] rc_ext;
   logic [COLS_W:0]      col_next;
   logic                 guard, sample, active, col_work;

   logic [2*HB-1:0] line_mem [MAX_COLS];
   logic [2*HB-1:0] rd_ff, byp_data_ff, entry, wdata;
   logic            byp_hit_ff;
   logic [AW-1:0]   raddr, waddr_ff;
   logic            wr_en;

   logic            b_valid_ff, b_clr_ff, b_act_ff, b_pre_ff, b_colw_ff;
   logic            b_first_ff, b_useprev_ff, b_late_ff, b_sample_ff;
   logic signed [HB-1:0] b_h_ff;
   logic signed [HB-1:0] prev_h, cur_h;
   logic signed [HB-1:0] col_v [3];
   logic signed [HB-1:0] win_ff [3][3];
   logic signed [HB-1:0] snap_ff [3][3];
   logic            go, emit, last;

   logic [ROWS_W-1:0] out_row_ff, out_row_in;
   logic [COLS_W-1:0] out_col_ff, out_col_in;
   emit_info_type     info_ff;

   // stage a: position decode and counters
   always_comb begin
      rc_ext   = ROW_CNT_W'(rc);
      guard    = (in_row_ff > rc_ext + ROW_CNT_W'(1)) || (in_col_ff >= cc);
      sample   = in_row_ff < rc_ext;
      active   = !guard && (sample != action);
      col_work = in_row_ff <= rc_ext;
      col_next = {1'b0, in_col_ff} + (COLS_W+1)'(1);
      raddr    = AW'(in_col_ff);
   end

   always_comb begin
      in_row_in = in_row_ff;
      in_col_in = in_col_ff;
      if (restart) begin
         in_row_in = '0;
         in_col_in = '0;
      end else if (accept) begin
         if (guard) begin
            in_row_in = '0;
            in_col_in = '0;
         end else if (active) begin
            if (col_work) begin
               if (col_next >= {1'b0, cc}) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + ROW_CNT_W'(1);
               end else begin
                  in_col_in = col_next[COLS_W-1:0];
               end
            end else begin
               in_row_in = '0;
               in_col_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      b_clr_ff     <= guard;
      b_act_ff     <= active;
      b_pre_ff     <= (in_col_ff == '0) && (in_row_ff >= ROW_CNT_W'(2));
      b_colw_ff    <= col_work;
      b_first_ff   <= in_col_ff == '0;
      b_useprev_ff <= in_row_ff >= ROW_CNT_W'(2);
      b_late_ff    <= col_work && (in_col_ff != '0) && (in_row_ff >= ROW_CNT_W'(1));
      b_sample_ff  <= sample;
      b_h_ff       <= height;
      waddr_ff     <= raddr;
   end

   // line buffer: {two rows back, one row back} per column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[waddr_ff] <= wdata;
      end
      rd_ff <= line_mem[raddr];
   end

   always_ff @(posedge clock) begin
      byp_hit_ff  <= wr_en && (waddr_ff == raddr);
      byp_data_ff <= wdata;
   end

   // stage b: column assembly and window
   always_comb begin
      entry     = byp_hit_ff ? byp_data_ff : rd_ff;
      prev_h    = entry[2*HB-1:HB];
      cur_h     = entry[HB-1:0];
      col_v[0]  = b_useprev_ff ? prev_h : cur_h;
      col_v[1]  = cur_h;
      col_v[2]  = b_sample_ff ? b_h_ff : cur_h;
      wdata     = {cur_h, b_h_ff};
      go        = b_valid_ff && b_act_ff;
      wr_en     = go && b_colw_ff && b_sample_ff;
      emit      = go && (b_pre_ff || b_late_ff);
      drop      = b_valid_ff && !emit;
      last      = (out_row_ff == rc - ROWS_W'(1)) && (out_col_ff == cc - COLS_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (go) begin
         if (b_colw_ff) begin
            if (b_first_ff) begin
               if (b_pre_ff) begin
                  win_ff[0] <= win_ff[1];
               end
               win_ff[1] <= col_v;
               win_ff[2] <= col_v;
            end else begin
               win_ff[0] <= win_ff[1];
               win_ff[1] <= win_ff[2];
               win_ff[2] <= col_v;
            end
         end else begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         snap_ff[0] <= win_ff[1];
         snap_ff[1] <= win_ff[2];
         if (b_pre_ff) begin
            snap_ff[2] <= win_ff[2];
         end else begin
            snap_ff[2] <= col_v;
         end
      end
   end

   // output cell position
   always_comb begin
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (restart || (b_valid_ff && b_clr_ff)) begin
         out_row_in = '0;
         out_col_in = '0;
      end else if (emit) begin
         if (last) begin
            out_row_in = '0;
            out_col_in = '0;
         end else if ({1'b0, out_col_ff} + (COLS_W+1)'(1) >= {1'b0, cc}) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROWS_W'(1);
         end else begin
            out_col_in = out_col_ff + COLS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         info_ff.valid <= 1'b0;
      end else begin
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         info_ff.valid <= emit;
      end
      info_ff.row  <= out_row_ff[OUT_ROW_W-1:0];
      info_ff.col  <= out_col_ff[OUT_COL_W-1:0];
      info_ff.last <= last;
   end

   assign info = info_ff;
   assign win  = snap_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tszc_back.sv @@
// Back part: eight slope lanes through a pipelined arctangent, then angle sums and the zone decision.
// Depends on tszc_pkg; takes window snapshots from tszc_front and writes tszc_out_queue.
`default_nettype none

module tszc_back import tszc_pkg::*; #(
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire emit_info_type                 info,
   input  wire logic signed [HEIGHT_BITS-1:0] win [3][3],
   input  wire thr_cfg_type                   cfg,
   output logic                               wr,
   output rsp_entry_type                      entry
);

   localparam int HB = HEIGHT_BITS;
   localparam int XW = HB + FRAC_BITS + 3;
   localparam int CW = (HB > THR_W) ? HB : THR_W;

   logic signed [HB-1:0] lhs [LANES];
   logic signed [HB-1:0] ctr;
   logic [HB-1:0]        mag [LANES];
   logic signed [HB:0]   dif [LANES];
   logic signed [CW-1:0] c_ext;
   logic [LANES-1:0]     zero_v;

   logic signed [XW-1:0]  x_ff [STEPS+1][LANES];
   logic signed [XW-1:0]  y_ff [STEPS+1][LANES];
   logic signed [Z_W-1:0] z_ff [STEPS+1][LANES];
   back_meta_type         meta_ff [STEPS+1];

   logic [ANG_W-1:0] ang [LANES];
   logic [SUM_W-1:0] sum_ff [DIRS];
   back_meta_type    meta_s_ff;
   logic             over_max, over_danger;

   function automatic logic [ANG_W-1:0] to_angle(input logic signed [Z_W-1:0] z,
                                                 input logic zero);
      logic [Z_W-1:0] zc;
      logic [Z_W-1:0] r;
      zc = z[Z_W-1] ? '0 : Z_W'(z);
      r  = (zc + Z_W'(ROUND_OFS)) >> ANG_SHIFT;
      if (zero) begin
         return '0;
      end else if (r > Z_W'(ANGLE_MAX)) begin
         return ANG_W'(ANGLE_MAX);
      end
      return r[ANG_W-1:0];
   endfunction

   // lane pairs: vertical, horizontal, rising and falling diagonal
   always_comb begin
      ctr    = win[1][1];
      lhs[0] = win[1][2];
      lhs[1] = win[1][0];
      lhs[2] = win[0][1];
      lhs[3] = win[2][1];
      lhs[4] = win[0][2];
      lhs[5] = win[2][0];
      lhs[6] = win[0][0];
      lhs[7] = win[2][2];
      for (int l = 0; l < LANES; l++) begin
         dif[l]    = (HB+1)'(lhs[l]) - (HB+1)'(ctr);
         mag[l]    = dif[l][HB] ? HB'(-dif[l]) : HB'(dif[l]);
         zero_v[l] = dif[l] == '0;
      end
      c_ext = CW'(ctr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff[0].valid <= 1'b0;
      end else begin
         meta_ff[0].valid <= info.valid;
      end
      meta_ff[0].row  <= info.row;
      meta_ff[0].col  <= info.col;
      meta_ff[0].last <= info.last;
      meta_ff[0].fly  <= c_ext > CW'(cfg.max_air);
      meta_ff[0].band <= (c_ext < CW'(cfg.min_land)) || (c_ext > CW'(cfg.max_land));
      meta_ff[0].zero <= zero_v;
      for (int l = 0; l < LANES; l++) begin
         x_ff[0][l] <= XW'(X_START) <<< FRAC_BITS;
         y_ff[0][l] <= XW'({mag[l], {FRAC_BITS{1'b0}}});
         z_ff[0][l] <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[i+1].valid <= 1'b0;
         end else begin
            meta_ff[i+1].valid <= meta_ff[i].valid;
         end
         meta_ff[i+1].row  <= meta_ff[i].row;
         meta_ff[i+1].col  <= meta_ff[i].col;
         meta_ff[i+1].last <= meta_ff[i].last;
         meta_ff[i+1].fly  <= meta_ff[i].fly;
         meta_ff[i+1].band <= meta_ff[i].band;
         meta_ff[i+1].zero <= meta_ff[i].zero;
         for (int l = 0; l < LANES; l++) begin
            if (!y_ff[i][l][XW-1]) begin
               x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
               y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
               z_ff[i+1][l] <= z_ff[i][l] + atan_step(4'(i));
            end else begin
               x_ff[i+1][l] <= x_ff[i][l] + ((-y_ff[i][l]) >>> i);
               y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
               z_ff[i+1][l] <= z_ff[i][l] - atan_step(4'(i));
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         ang[l] = to_angle(z_ff[STEPS][l], meta_ff[STEPS].zero[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_s_ff.valid <= 1'b0;
      end else begin
         meta_s_ff.valid <= meta_ff[STEPS].valid;
      end
      meta_s_ff.row  <= meta_ff[STEPS].row;
      meta_s_ff.col  <= meta_ff[STEPS].col;
      meta_s_ff.last <= meta_ff[STEPS].last;
      meta_s_ff.fly  <= meta_ff[STEPS].fly;
      meta_s_ff.band <= meta_ff[STEPS].band;
      meta_s_ff.zero <= meta_ff[STEPS].zero;
      for (int k = 0; k < DIRS; k++) begin
         sum_ff[k] <= SUM_W'(ang[2*k]) + SUM_W'(ang[2*k+1]);
      end
   end

   always_comb begin
      over_max    = 1'b0;
      over_danger = 1'b0;
      for (int k = 0; k < DIRS; k++) begin
         if (sum_ff[k] > {cfg.max_angle, 1'b0}) begin
            over_max = 1'b1;
         end
         if (sum_ff[k] > {cfg.danger_angle, 1'b0}) begin
            over_danger = 1'b1;
         end
      end
      wr         = meta_s_ff.valid;
      entry.row  = meta_s_ff.row;
      entry.col  = meta_s_ff.col;
      entry.fly  = meta_s_ff.fly;
      entry.last = meta_s_ff.last;
      if (over_max || meta_s_ff.band) begin
         entry.go = GO_FORBIDDEN;
      end else if (over_danger) begin
         entry.go = GO_DANGER;
      end else begin
         entry.go = GO_NORMAL;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tszc_out_queue.sv @@
// Result queue between the back pipeline and the response channel.
// Depends on tszc_pkg for the entry type.
`default_nettype none

module tszc_out_queue import tszc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_entry_type push_data,
   input  wire logic          pop,
   output logic               empty,
   output rsp_entry_type      head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   rsp_entry_type  mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic           do_pop;

   always_comb begin
      empty     = count_ff == '0;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CNTW'(push) - CNTW'(do_pop);
      head     = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/terrain_slope_zone_classifier_unit.sv @@
// Top level of the terrain slope zone classifier: control registers, credit counter and wiring.
// Depends on tszc_pkg, tszc_front, tszc_back and tszc_out_queue.
//
// Usage:
//   req channel: push a height sample (action 0) in raster order or a flush tick (action 1)
//   whenever full is low. After the last sample of a map, col_count + 1 flush ticks drain it.
//   rsp channel: while empty is low the oldest cell result is on the rsp_ ports; pop takes it.
//   csr channel: csr_ready is always high; writing row_count or col_count restarts the map.
// Throughput: one transaction per cycle while full is low.
// A result reaches the rsp ports after the accepting edge of the transaction that completes
//   its window, passing the front register, window snapshot, a difference stage,
//   16 arctangent stages, a sum stage and the queue write.
// Up to 32 transactions are in flight, bounded by the result queue depth; when the receiver
// stalls the queue fills and full rises once 32 are outstanding.
// Reset restores all control registers to their defaults and empties the pipeline.
// Line buffers are not cleared; a new map never uses a stored column before writing it.
`default_nettype none

module terrain_slope_zone_classifier_unit import tszc_pkg::*; #(
   parameter int MAX_COLS    = MAX_COLS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_action,
   input  wire logic signed [HEIGHT_BITS-1:0] req_height,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [OUT_ROW_W-1:0]               rsp_cell_row,
   output logic [OUT_COL_W-1:0]               rsp_cell_col,
   output logic [GO_W-1:0]                    rsp_go_class,
   output logic                               rsp_fly_forbidden,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [THR_W-1:0]              csr_wdata
);

   localparam int OCCW = $clog2(QUEUE_DEPTH + 1);

   logic [ROWS_W-1:0] row_count_ff, rc;
   logic [COLS_W-1:0] col_count_ff, cc;
   thr_cfg_type       cfg_ff;
   logic              csr_wr, restart;
   logic              accept, drop, q_push, do_pop;
   logic [OCCW-1:0]   occ_ff, occ_in;
   emit_info_type     info;
   logic signed [HEIGHT_BITS-1:0] win [3][3];
   rsp_entry_type     q_data, head;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff        <= ROWS_W'(4096);
         col_count_ff        <= COLS_W'(1024);
         cfg_ff.max_air      <= THR_W'(139);
         cfg_ff.min_land     <= THR_W'(73);
         cfg_ff.max_land     <= THR_W'(120);
         cfg_ff.danger_angle <= ANG_W'(640);
         cfg_ff.max_angle    <= ANG_W'(1120);
      end else if (csr_wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_COUNT:    row_count_ff        <= csr_wdata[ROWS_W-1:0];
            CSR_COL_COUNT:    col_count_ff        <= csr_wdata[COLS_W-1:0];
            CSR_MAX_AIR:      cfg_ff.max_air      <= csr_wdata;
            CSR_MIN_LAND:     cfg_ff.min_land     <= csr_wdata;
            CSR_MAX_LAND:     cfg_ff.max_land     <= csr_wdata;
            CSR_DANGER_ANGLE: cfg_ff.danger_angle <= csr_wdata[ANG_W-1:0];
            CSR_MAX_ANGLE:    cfg_ff.max_angle    <= csr_wdata[ANG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      restart = csr_wr && ((csr_index_type'(csr_index) == CSR_ROW_COUNT) ||
                           (csr_index_type'(csr_index) == CSR_COL_COUNT));
      if (row_count_ff == '0) begin
         rc = ROWS_W'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rc = ROWS_W'(MAX_ROWS);
      end else begin
         rc = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cc = COLS_W'(1);
      end else if (32'(col_count_ff) > MAX_COLS) begin
         cc = COLS_W'(MAX_COLS);
      end else begin
         cc = col_count_ff;
      end
   end

   // transactions in flight that may still hold a queue slot
   always_comb begin
      req_full = occ_ff >= OCCW'(QUEUE_DEPTH);
      accept   = req_push && !req_full;
      do_pop   = rsp_pop && !rsp_empty;
      occ_in   = occ_ff + OCCW'(accept) - OCCW'(drop) - OCCW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   tszc_front #(
      .MAX_COLS    (MAX_COLS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .rc      (rc),
      .cc      (cc),
      .accept  (accept),
      .action  (req_action),
      .height  (req_height),
      .drop    (drop),
      .info    (info),
      .win     (win)
   );

   tszc_back #(
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .info  (info),
      .win   (win),
      .cfg   (cfg_ff),
      .wr    (q_push),
      .entry (q_data)
   );

   tszc_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_cell_row      = head.row;
   assign rsp_cell_col      = head.col;
   assign rsp_go_class      = head.go;
   assign rsp_fly_forbidden = head.fly;
   assign rsp_last          = head.last;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for terrain_slope_zone_classifier_unit: streams height maps with random gaps and
// stalls, predicts each cell's zone in its own model and checks every popped result.
// Depends on tszc_pkg and the classifier RTL.
`default_nettype none

module tb_top;
   import tszc_pkg::*;

   localparam longint ATAN_TAB [16] = '{46080, 27203, 14373, 7296, 3662, 1833, 917, 458,
                                        229, 115, 57, 29, 14, 7, 4, 2};
   localparam bit ACT_SAMPLE = 1'b0;
   localparam bit ACT_FLUSH  = 1'b1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic                    req_action = ACT_SAMPLE;
   logic signed [15:0]      req_height = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [OUT_ROW_W-1:0]    rsp_cell_row;
   logic [OUT_COL_W-1:0]    rsp_cell_col;
   logic [GO_W-1:0]         rsp_go_class;
   logic                    rsp_fly_forbidden;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_ROW_COUNT;
   logic [THR_W-1:0]        csr_wdata = '0;

   terrain_slope_zone_classifier_unit dut (.*);

   always #1 clock = ~clock;

   // zone model state
   longint unsigned rows_reg, cols_reg, danger_reg, max_ang_reg;
   longint          air_reg, min_land_reg, max_land_reg;
   longint          prev_line [1024];
   longint          cur_line [1024];
   longint          win [3][3];
   longint unsigned in_row, in_col, out_row, out_col;
   rsp_entry_type   cell_q [$];

   int  errors = 0;
   int  items_sent = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;

   function automatic longint slope_angle(longint a, longint b);
      longint d, x, y, z, nx, r;
      d = a > b ? a - b : b - a;
      if (d == 0) return 0;
      x = 6 <<< 14;
      y = d * 16384;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ATAN_TAB[i];
         end else begin
            nx = x + ((-y) >>> i);
            y  = y + (x >>> i);
            z -= ATAN_TAB[i];
         end
         x = nx;
      end
      if (z < 0) z = 0;
      r = (z + 32) >>> 6;
      return r > 1440 ? 1440 : r;
   endfunction

   function automatic longint unsigned rows_used();
      if (rows_reg == 0) return 1;
      return rows_reg > 4096 ? 4096 : rows_reg;
   endfunction

   function automatic longint unsigned cols_used();
      if (cols_reg == 0) return 1;
      return cols_reg > 1024 ? 1024 : cols_reg;
   endfunction

   function automatic void classify_cell(longint unsigned rc, longint unsigned cc);
      longint          c;
      longint unsigned s [4];
      bit              over_max, over_danger, is_last;
      rsp_entry_type   e;
      c = win[1][1];
      s[0] = slope_angle(win[1][2], c) + slope_angle(c, win[1][0]);
      s[1] = slope_angle(win[0][1], c) + slope_angle(c, win[2][1]);
      s[2] = slope_angle(win[0][2], c) + slope_angle(c, win[2][0]);
      s[3] = slope_angle(win[0][0], c) + slope_angle(c, win[2][2]);
      over_max = 0;
      over_danger = 0;
      for (int k = 0; k < 4; k++) begin
         if (s[k] > 2 * max_ang_reg) over_max = 1;
         if (s[k] > 2 * danger_reg) over_danger = 1;
      end
      is_last = (out_row == rc - 1) && (out_col == cc - 1);
      e.row = out_row[OUT_ROW_W-1:0];
      e.col = out_col[OUT_COL_W-1:0];
      if (over_max || c < min_land_reg || c > max_land_reg) e.go = GO_FORBIDDEN;
      else e.go = over_danger ? GO_DANGER : GO_NORMAL;
      e.fly = c > air_reg;
      e.last = is_last;
      cell_q.push_back(e);
      if (is_last) begin
         out_row = 0;
         out_col = 0;
      end else if (out_col + 1 >= cc) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   function automatic void zone_step(bit act, logic signed [15:0] h);
      longint unsigned rc, cc, ix;
      longint          a, b;
      longint          col [3];
      bit              sample;
      rc = rows_used();
      cc = cols_used();
      sample = in_row < rc;
      if (in_row > rc + 1 || in_col >= cc) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         return;
      end
      if (sample == act) return;
      if (in_col == 0 && in_row >= 2) begin
         win[0] = win[1];
         win[1] = win[2];
         classify_cell(rc, cc);
      end
      if (in_row <= rc) begin
         ix = in_col;
         a = prev_line[ix];
         b = cur_line[ix];
         col[0] = in_row >= 2 ? a : b;
         col[1] = b;
         col[2] = b;
         if (sample) begin
            col[2] = h;
            prev_line[ix] = b;
            cur_line[ix] = h;
         end
         if (in_col == 0) begin
            win[1] = col;
            win[2] = col;
         end else begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = col;
            if (in_row >= 1) classify_cell(rc, cc);
         end
         in_col++;
         if (in_col >= cc) begin
            in_col = 0;
            in_row++;
         end
      end else begin
         in_row = 0;
         in_col = 0;
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic send_item(bit act, logic signed [15:0] h);
      int g;
      req_push <= 1'b1;
      req_action <= act;
      req_height <= h;
      do @(posedge clock); while (req_full);
      zone_step(act, h);
      items_sent++;
      g = gap_len();
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (cell_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ROW_COUNT:    rows_reg = val & 16'h1FFF;
         CSR_COL_COUNT:    cols_reg = val & 16'h07FF;
         CSR_MAX_AIR:      air_reg = longint'($signed(val));
         CSR_MIN_LAND:     min_land_reg = longint'($signed(val));
         CSR_MAX_LAND:     max_land_reg = longint'($signed(val));
         CSR_DANGER_ANGLE: danger_reg = val & 16'h07FF;
         CSR_MAX_ANGLE:    max_ang_reg = val & 16'h07FF;
         default: ;
      endcase
      if (idx == CSR_ROW_COUNT || idx == CSR_COL_COUNT) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end
   endtask

   task automatic set_map(int rows, int cols);
      wait_idle();
      write_reg(CSR_ROW_COUNT, rows[15:0]);
      write_reg(CSR_COL_COUNT, cols[15:0]);
   endtask

   task automatic set_limits(int air, int lo, int hi, int dang, int maxa);
      wait_idle();
      write_reg(CSR_MAX_AIR, air[15:0]);
      write_reg(CSR_MIN_LAND, lo[15:0]);
      write_reg(CSR_MAX_LAND, hi[15:0]);
      write_reg(CSR_DANGER_ANGLE, dang[15:0]);
      write_reg(CSR_MAX_ANGLE, maxa[15:0]);
   endtask

   function automatic logic signed [15:0] pick_height(int base);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 16'sh8000;
      if (r < 6) return 16'sh7FFF;
      if (r < 14) return $urandom();
      return base + $urandom_range(0, 24) - 12;
   endfunction

   // one whole map plus its drain, with occasional out-of-order actions
   task automatic run_map(int base, int noise_pct);
      longint unsigned rc, cc;
      rc = rows_used();
      cc = cols_used();
      quiet = ($urandom_range(0, 4) == 0);
      for (longint unsigned i = 0; i < rc * cc; i++) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(ACT_FLUSH, $urandom());
         send_item(ACT_SAMPLE, pick_height(base));
      end
      for (longint unsigned i = 0; i <= cc; i++) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(ACT_SAMPLE, $urandom());
         send_item(ACT_FLUSH, $urandom());
      end
      quiet = 1'b0;
   endtask

   // the start of a large map, cut short by the next count write
   task automatic run_partial(int count);
      for (int i = 0; i < count; i++) send_item(ACT_SAMPLE, pick_height(100));
   endtask

   task automatic test_directed_map();
      logic signed [15:0] hts [12];
      hts = '{16'sd100, 16'sd100, 16'sh7FFF, 16'sd95, 16'sh8000, 16'sd0, 16'sd110, 16'sd101,
              16'sd140, 16'sd72, 16'sd73, 16'sd120};
      set_map(3, 4);
      send_item(ACT_FLUSH, 16'sd0);
      foreach (hts[i]) send_item(ACT_SAMPLE, hts[i]);
      send_item(ACT_SAMPLE, 16'sd5);
      repeat (5) send_item(ACT_FLUSH, 16'shFFFF);
   endtask

   task automatic test_count_limits();
      set_map(0, 0);
      run_map(100, 0);
      set_map(1, 1);
      run_map(100, 10);
      set_map(8191, 1);
      run_partial(40);
      set_map(2, 2047);
      run_partial(1030);
      set_map(3, 5);
      run_map(100, 0);
      wait_idle();
      write_reg(CSR_COL_COUNT, 16'd3);
      run_map(100, 0);
   endtask

   task automatic test_limit_sweep();
      set_map(3, 6);
      set_limits(-32768, -32768, 32767, 0, 0);
      run_map(100, 5);
      set_limits(32767, 32767, -32768, 1440, 1440);
      run_map(100, 5);
      set_limits(100, 90, 110, 2047, 2047);
      run_map(100, 5);
      set_limits(0, -20, 20, 150, 300);
      run_map(0, 5);
   endtask

   task automatic test_random_maps();
      int lo;
      while (items_sent < 1600) begin
         set_map($urandom_range(1, 7), $urandom_range(1, 14));
         lo = $urandom_range(0, 200) - 100;
         if ($urandom_range(0, 3) == 0)
            set_limits($urandom(), $urandom(), $urandom(), $urandom_range(0, 1440),
                       $urandom_range(0, 1440));
         else
            set_limits(lo + $urandom_range(0, 60), lo, lo + $urandom_range(0, 60),
                       $urandom_range(0, 700), $urandom_range(300, 1440));
         run_map(lo + 30, 4);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_pop <= 1'b0;
      end else if (quiet) begin
         rsp_pop <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         stall_left <= $urandom_range(10, 60);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= $urandom_range(0, 99) < 75;
      end
   end

   always @(posedge clock) begin
      rsp_entry_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (cell_q.size() == 0) begin
            report_mismatch($sformatf("unexpected cell %0d,%0d", rsp_cell_row, rsp_cell_col));
         end else begin
            e = cell_q.pop_front();
            if (rsp_cell_row !== e.row)
               report_mismatch($sformatf("row %0d want %0d", rsp_cell_row, e.row));
            if (rsp_cell_col !== e.col)
               report_mismatch($sformatf("col %0d want %0d", rsp_cell_col, e.col));
            if (rsp_go_class !== e.go)
               report_mismatch($sformatf("go_class %0d want %0d at %0d,%0d",
                                         rsp_go_class, e.go, e.row, e.col));
            if (rsp_fly_forbidden !== e.fly)
               report_mismatch($sformatf("fly %0b want %0b at %0d,%0d",
                                         rsp_fly_forbidden, e.fly, e.row, e.col));
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last %0b want %0b at %0d,%0d",
                                         rsp_last, e.last, e.row, e.col));
         end
      end
   end

   initial begin
      rows_reg = 4096; cols_reg = 1024;
      air_reg = 139; min_land_reg = 73; max_land_reg = 120;
      danger_reg = 640; max_ang_reg = 1120;
      foreach (prev_line[i]) begin
         prev_line[i] = 0;
         cur_line[i] = 0;
      end
      foreach (win[i, j]) win[i][j] = 0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_map();
      test_count_limits();
      test_limit_sweep();
      test_random_maps();
      wait_idle();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout, %0d cells outstanding", cell_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

@@ terrain_slope_zone_classifier_unit.f @@
hw/rtl/tszc_pkg.sv
hw/rtl/tszc_front.sv
hw/rtl/tszc_back.sv
hw/rtl/tszc_out_queue.sv
hw/rtl/terrain_slope_zone_classifier_unit.sv
tb/sv/tb_top.sv
